// ----- hw/rtl/mcbq_pkg.sv -----
`default_nettype none

package mcbq_pkg;

  localparam int COEF_W   = 32;
  localparam int SAMPLE_W = 24;
  localparam int DELAY_W  = 40;
  localparam int CHAN_W   = 3;
  localparam int ACTIVE_W = 4;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  localparam logic [2:0] REG_B0     = 3'd0;
  localparam logic [2:0] REG_B1     = 3'd1;
  localparam logic [2:0] REG_B2     = 3'd2;
  localparam logic [2:0] REG_A1     = 3'd3;
  localparam logic [2:0] REG_A2     = 3'd4;
  localparam logic [2:0] REG_ACTIVE = 3'd5;

  localparam logic [COEF_W-1:0] RESET_B0 = 32'h4000_0000;

  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  typedef struct packed {
    logic                       command;
    logic [CHAN_W-1:0]          channel;
    logic signed [SAMPLE_W-1:0] sample_in;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0]          channel_out;
    logic signed [SAMPLE_W-1:0] sample_out;
  } out_item_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
    logic [ACTIVE_W-1:0]      active;
  } cfg_t;

  typedef enum logic [2:0] {
    COEF_B0,
    COEF_B1,
    COEF_B2,
    COEF_A1,
    COEF_A2
  } coef_sel_t;

  typedef enum logic [1:0] {
    SRC_W1,
    SRC_W2,
    SRC_W
  } src_sel_t;

  typedef struct packed {
    logic      accept;
    logic      clear;
    coef_sel_t coef_sel;
    src_sel_t  src_sel;
    logic      mul_hi;
    logic      t_load;
    logic      t_add;
    logic      sw_sub;
    logic      w_latch;
    logic      sy_load;
    logic      sy_add;
    logic      out_load;
    logic      out_pass;
    logic      mem_write;
  } dp_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic is_pass;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mcbq_regs.sv -----
`default_nettype none

module mcbq_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mcbq_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [mcbq_pkg::DATA_W-1:0]   pwdata,
  output logic      [mcbq_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  output mcbq_pkg::cfg_t                     cfg
);
  import mcbq_pkg::*;

  logic [2:0] index;
  logic       wr_en;

  assign index  = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.b0     <= RESET_B0;
      cfg.b1     <= '0;
      cfg.b2     <= '0;
      cfg.a1     <= '0;
      cfg.a2     <= '0;
      cfg.active <= '0;
    end else if (wr_en) begin
      case (index)
        REG_B0:     cfg.b0     <= pwdata;
        REG_B1:     cfg.b1     <= pwdata;
        REG_B2:     cfg.b2     <= pwdata;
        REG_A1:     cfg.a1     <= pwdata;
        REG_A2:     cfg.a2     <= pwdata;
        REG_ACTIVE: cfg.active <= pwdata[ACTIVE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_B0:     prdata = cfg.b0;
      REG_B1:     prdata = cfg.b1;
      REG_B2:     prdata = cfg.b2;
      REG_A1:     prdata = cfg.a1;
      REG_A2:     prdata = cfg.a2;
      REG_ACTIVE: prdata = {{(DATA_W-ACTIVE_W){1'b0}}, cfg.active};
      default:    prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/mcbq_ctrl.sv -----
`default_nettype none

module mcbq_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire mcbq_pkg::dp_stat_t  stat,
  output mcbq_pkg::dp_cmd_t        cmd
);
  import mcbq_pkg::*;

  typedef enum logic [13:0] {
    ST_IDLE   = 14'h0001,
    ST_A1_LO  = 14'h0002,
    ST_A1_HI  = 14'h0004,
    ST_A2_LO  = 14'h0008,
    ST_A2_HI  = 14'h0010,
    ST_B1_LO  = 14'h0020,
    ST_B1_HI  = 14'h0040,
    ST_B2_LO  = 14'h0080,
    ST_B2_HI  = 14'h0100,
    ST_B0_LO  = 14'h0200,
    ST_B0_HI  = 14'h0400,
    ST_B0_ACC = 14'h0800,
    ST_B0_RND = 14'h1000,
    ST_DONE   = 14'h2000
  } state_t;

  state_t state;
  state_t state_next;
  logic   pass;
  logic   accept;
  logic   out_free;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_ready && in_valid;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        cmd.accept = accept;
        cmd.clear  = accept && stat.is_clear;
        if (accept && !stat.is_clear) begin
          state_next = stat.is_pass ? ST_DONE : ST_A1_LO;
        end
      end
      ST_A1_LO: begin
        cmd.coef_sel = COEF_A1;
        cmd.src_sel  = SRC_W1;
        state_next   = ST_A1_HI;
      end
      ST_A1_HI: begin
        cmd.coef_sel = COEF_A1;
        cmd.src_sel  = SRC_W1;
        cmd.mul_hi   = 1'b1;
        cmd.t_load   = 1'b1;
        state_next   = ST_A2_LO;
      end
      ST_A2_LO: begin
        cmd.coef_sel = COEF_A2;
        cmd.src_sel  = SRC_W2;
        cmd.t_add    = 1'b1;
        state_next   = ST_A2_HI;
      end
      ST_A2_HI: begin
        cmd.coef_sel = COEF_A2;
        cmd.src_sel  = SRC_W2;
        cmd.mul_hi   = 1'b1;
        cmd.t_load   = 1'b1;
        cmd.sw_sub   = 1'b1;
        state_next   = ST_B1_LO;
      end
      ST_B1_LO: begin
        cmd.coef_sel = COEF_B1;
        cmd.src_sel  = SRC_W1;
        cmd.t_add    = 1'b1;
        state_next   = ST_B1_HI;
      end
      ST_B1_HI: begin
        cmd.coef_sel = COEF_B1;
        cmd.src_sel  = SRC_W1;
        cmd.mul_hi   = 1'b1;
        cmd.t_load   = 1'b1;
        cmd.sw_sub   = 1'b1;
        state_next   = ST_B2_LO;
      end
      ST_B2_LO: begin
        cmd.coef_sel = COEF_B2;
        cmd.src_sel  = SRC_W2;
        cmd.t_add    = 1'b1;
        cmd.w_latch  = 1'b1;
        state_next   = ST_B2_HI;
      end
      ST_B2_HI: begin
        cmd.coef_sel = COEF_B2;
        cmd.src_sel  = SRC_W2;
        cmd.mul_hi   = 1'b1;
        cmd.t_load   = 1'b1;
        cmd.sy_load  = 1'b1;
        state_next   = ST_B0_LO;
      end
      ST_B0_LO: begin
        cmd.coef_sel = COEF_B0;
        cmd.src_sel  = SRC_W;
        cmd.t_add    = 1'b1;
        state_next   = ST_B0_HI;
      end
      ST_B0_HI: begin
        cmd.coef_sel = COEF_B0;
        cmd.src_sel  = SRC_W;
        cmd.mul_hi   = 1'b1;
        cmd.t_load   = 1'b1;
        cmd.sy_add   = 1'b1;
        state_next   = ST_B0_ACC;
      end
      ST_B0_ACC: begin
        cmd.t_add  = 1'b1;
        state_next = ST_B0_RND;
      end
      ST_B0_RND: begin
        cmd.sy_add = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_pass  = pass;
          cmd.mem_write = !pass;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pass      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        pass <= stat.is_pass;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/mcbq_dp.sv -----
`default_nettype none

module mcbq_dp #(
  parameter int CHANNELS = 8
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire mcbq_pkg::cfg_t      cfg,
  input  wire mcbq_pkg::in_item_t  in_item,
  input  wire mcbq_pkg::dp_cmd_t   cmd,
  output mcbq_pkg::dp_stat_t       stat,
  output mcbq_pkg::out_item_t      out_item
);
  import mcbq_pkg::*;

  localparam int CHAN_SPAN = 2 ** CHAN_W;
  localparam int DEPTH     = (CHANNELS < CHAN_SPAN) ? CHANNELS : CHAN_SPAN;
  localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OP_W      = 21;
  localparam int PROD_W    = COEF_W + OP_W;
  localparam int ACC_W     = 72;
  localparam int SUM_W     = 46;
  localparam int TERM_W    = ACC_W - 30;
  localparam int WORD_W    = 2 * DELAY_W;
  localparam logic [6:0]       CH_LIMIT = 7'(CHANNELS);
  localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(1) << 29;

  function automatic logic [DELAY_W-1:0] sat_delay(input logic [SUM_W-1:0] v);
    logic pos_ovf;
    logic neg_ovf;
    pos_ovf = !v[SUM_W-1] && (v[SUM_W-2:DELAY_W-1] != '0);
    neg_ovf = v[SUM_W-1] && (v[SUM_W-2:DELAY_W-1] != '1);
    if (pos_ovf) begin
      return {1'b0, {(DELAY_W-1){1'b1}}};
    end else if (neg_ovf) begin
      return {1'b1, {(DELAY_W-1){1'b0}}};
    end
    return v[DELAY_W-1:0];
  endfunction

  function automatic logic [SAMPLE_W-1:0] sat_sample(input logic [SUM_W-1:0] v);
    logic pos_ovf;
    logic neg_ovf;
    pos_ovf = !v[SUM_W-1] && (v[SUM_W-2:SAMPLE_W-1] != '0);
    neg_ovf = v[SUM_W-1] && (v[SUM_W-2:SAMPLE_W-1] != '1);
    if (pos_ovf) begin
      return {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (neg_ovf) begin
      return {1'b1, {(SAMPLE_W-1){1'b0}}};
    end
    return v[SAMPLE_W-1:0];
  endfunction

  logic [WORD_W-1:0]          mem [DEPTH];
  logic [DEPTH-1:0]           vld;
  logic [WORD_W-1:0]          rd_word;
  logic                       rd_vld;
  logic [CHAN_W-1:0]          ch_q;
  logic [SAMPLE_W-1:0]        x_q;
  logic signed [PROD_W-1:0]   prod;
  logic [ACC_W-1:0]           acc;
  logic [SUM_W-1:0]           sum_w;
  logic [SUM_W-1:0]           sum_y;
  logic [DELAY_W-1:0]         w_q;

  logic [IDX_W-1:0]           in_idx;
  logic [IDX_W-1:0]           wr_idx;
  logic [DELAY_W-1:0]         w1;
  logic [DELAY_W-1:0]         w2;
  logic [DELAY_W-1:0]         src;
  logic signed [COEF_W-1:0]   coef_m;
  logic signed [OP_W-1:0]     op_m;
  logic [ACC_W-1:0]           acc_rnd;
  logic [SUM_W-1:0]           term;

  assign in_idx = in_item.channel[IDX_W-1:0];
  assign wr_idx = ch_q[IDX_W-1:0];
  assign w1     = rd_vld ? rd_word[WORD_W-1:DELAY_W] : '0;
  assign w2     = rd_vld ? rd_word[DELAY_W-1:0] : '0;

  assign stat.is_clear = (in_item.command == CMD_CLEAR);
  assign stat.is_pass  = !(({1'b0, in_item.channel} < cfg.active) &&
                           ({4'd0, in_item.channel} < CH_LIMIT));

  always_comb begin
    case (cmd.coef_sel)
      COEF_B0: coef_m = cfg.b0;
      COEF_B1: coef_m = cfg.b1;
      COEF_B2: coef_m = cfg.b2;
      COEF_A1: coef_m = cfg.a1;
      COEF_A2: coef_m = cfg.a2;
      default: coef_m = '0;
    endcase
    case (cmd.src_sel)
      SRC_W1:  src = w1;
      SRC_W2:  src = w2;
      SRC_W:   src = w_q;
      default: src = '0;
    endcase
    if (cmd.mul_hi) begin
      op_m = {src[DELAY_W-1], src[DELAY_W-1:20]};
    end else begin
      op_m = {1'b0, src[19:0]};
    end
  end

  assign acc_rnd = acc + RND_HALF;
  assign term    = {{(SUM_W-TERM_W){acc_rnd[ACC_W-1]}}, acc_rnd[ACC_W-1:30]};

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_word <= mem[in_idx];
    end
    if (cmd.mem_write) begin
      mem[wr_idx] <= {w_q, w1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      vld <= '0;
    end else if (cmd.mem_write) begin
      vld[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_vld <= vld[in_idx];
      ch_q   <= in_item.channel;
      x_q    <= in_item.sample_in;
      sum_w  <= {{(SUM_W-SAMPLE_W){in_item.sample_in[SAMPLE_W-1]}}, in_item.sample_in};
    end else if (cmd.sw_sub) begin
      sum_w <= sum_w - term;
    end
    prod <= coef_m * op_m;
    if (cmd.t_load) begin
      acc <= {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    end else if (cmd.t_add) begin
      acc <= acc + {prod[ACC_W-21:0], 20'd0};
    end
    if (cmd.w_latch) begin
      w_q <= sat_delay(sum_w);
    end
    if (cmd.sy_load) begin
      sum_y <= term;
    end else if (cmd.sy_add) begin
      sum_y <= sum_y + term;
    end
    if (cmd.out_load) begin
      out_item.channel_out <= ch_q;
      out_item.sample_out  <= cmd.out_pass ? x_q : sat_sample(sum_y);
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/multichannel_biquad_df2.sv -----
// A filtered sample is accepted and its result is valid once the single shared 32 x 21 bit
// multiplier has made two passes for each of the five coefficient products and the sum is rounded;
// no new sample is taken until that result is loaded into the output, which waits on out_ready.
// A pass-through sample skips the multiplier passes; a clear resets the valid bits and gives no output.
// Synchronous reset loads the reset coefficients and zeroes every delay word at once through
// per-channel valid bits, so no clearing pass follows reset.
`default_nettype none

module multichannel_biquad_df2 #(
  parameter int CHANNELS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire mcbq_pkg::in_item_t            in_item,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output mcbq_pkg::out_item_t                out_item,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mcbq_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [mcbq_pkg::DATA_W-1:0]   pwdata,
  output logic      [mcbq_pkg::DATA_W-1:0]   prdata,
  output logic                               pready
);
  import mcbq_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  mcbq_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mcbq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mcbq_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_item)
  );

endmodule

`default_nettype wire
